@@ rtl/linear_scan_register_allocator_assert.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_ASSERT_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LSRA_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LSRA_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/lsra_pkg.sv @@
package lsra_pkg;

  // Number of physical register slots held in the table.
  localparam int SLOT_COUNT = 16;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  localparam int ID_W      = 16;
  localparam int TIME_W    = 16;
  localparam int LEN_W     = TIME_W + 1;
  localparam int ASSIGN_W  = 4;
  localparam int CFG_W     = 5;
  localparam int PADDR_W   = 3;
  localparam int PDATA_W   = 32;

  // Register map.
  localparam logic [PADDR_W-1:0] ADDR_ACTIVE_REGISTERS = 3'h0;
  localparam logic [CFG_W-1:0]   ACTIVE_RESET          = 5'd16;

  typedef logic [IDX_W-1:0] slot_idx_t;

  // One slot of the table as held in memory.
  typedef struct packed {
    logic [ID_W-1:0]   vreg;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
  } slot_entry_t;

  localparam int ENTRY_W = $bits(slot_entry_t);

  // Outcome of one scan over the table.
  typedef struct packed {
    logic                    found;
    slot_idx_t               free_idx;
    slot_idx_t               vic_idx;
    logic [ID_W-1:0]         vic_vreg;
    logic [TIME_W-1:0]       vic_end;
    logic signed [LEN_W-1:0] vic_len;
  } scan_res_t;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  // Signed length of an interval.
  function automatic logic signed [LEN_W-1:0] span_of(input logic [TIME_W-1:0] s,
                                                       input logic [TIME_W-1:0] e);
    span_of = $signed({1'b0, e}) - $signed({1'b0, s});
  endfunction

endpackage

@@ rtl/lsra_ram.sv @@
module lsra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port, registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ rtl/lsra_scan.sv @@
module lsra_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          clear,
  input  logic                          eval,
  input  lsra_pkg::slot_idx_t           eval_idx,
  input  lsra_pkg::slot_entry_t         entry,
  input  logic                          entry_valid,
  input  logic [lsra_pkg::TIME_W-1:0]   new_start,
  output lsra_pkg::scan_res_t           res
);

  import lsra_pkg::*;

  logic                    slot_free;
  logic signed [LEN_W-1:0] entry_len;
  logic                    better;

  // A slot is free if empty or if its interval has expired.
  assign slot_free = !entry_valid || (entry.end_time <= new_start);
  assign entry_len = span_of(entry.start_time, entry.end_time);

  // Victim order: latest end, then shortest length, then larger id.
  always_comb begin
    priority if (eval_idx == '0) begin
      better = 1'b1;
    end else if (entry.end_time > res.vic_end) begin
      better = 1'b1;
    end else if (entry.end_time == res.vic_end) begin
      better = (entry_len < res.vic_len) ||
               ((entry_len == res.vic_len) && (entry.vreg > res.vic_vreg));
    end else begin
      better = 1'b0;
    end
  end

  // First free slot in scan order, and the running victim.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      res.found <= 1'b0;
    end else if (eval && slot_free && !res.found) begin
      res.found <= 1'b1;
    end
    if (eval && slot_free && !res.found) begin
      res.free_idx <= eval_idx;
    end
    if (eval && better) begin
      res.vic_idx  <= eval_idx;
      res.vic_vreg <= entry.vreg;
      res.vic_end  <= entry.end_time;
      res.vic_len  <= entry_len;
    end
  end

endmodule

@@ rtl/linear_scan_register_allocator.sv @@
// Linear-scan register allocator.
// Input channel (in_valid/in_ready) takes one live interval word per item:
// interval_id, interval_start, interval_end and last_interval, in start order.
// Output channel (out_valid/out_ready) returns one result word per item:
// the assigned register, spill and eviction flags, the evicted id and the
// sticky any_spill flag. The APB port holds active_registers at address 0.
// Each accepted item scans the first k slots, where k is the effective
// register count (1 to 16). The slot table lives in a single-port-read memory
// that is read one slot per cycle. A new item is taken once the previous
// result has been loaded into the output register, so one item is scanned
// at a time.
// Reset clears all slot valid bits and the spill flag and sets
// active_registers to 16; the memory itself is not cleared and needs no pass.
// If the receiver stalls, the result waits in the output register and the
// next item is scanned; it then holds until the output register is free.
// After an item with last_interval set, all slots and the spill flag clear.
module linear_scan_register_allocator (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] interval_id,
  input  logic [15:0] interval_start,
  input  logic [15:0] interval_end,
  input  logic        last_interval,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  assigned_register,
  output logic        spilled,
  output logic        spill_event,
  output logic        evicted_valid,
  output logic [15:0] evicted_id,
  output logic        any_spill,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [lsra_pkg::PADDR_W-1:0] paddr,
  input  logic [lsra_pkg::PDATA_W-1:0] pwdata,
  output logic [lsra_pkg::PDATA_W-1:0] prdata,
  output logic        pready
);

  import lsra_pkg::*;

  state_t                  state;
  logic [CFG_W-1:0]        active_registers;
  logic [CNT_W-1:0]        k;
  logic [SLOT_COUNT-1:0]   slot_valid;
  logic                    spill_seen;

  logic [ID_W-1:0]         cur_id;
  logic [TIME_W-1:0]       cur_start;
  logic [TIME_W-1:0]       cur_end;
  logic                    cur_last;

  logic [CNT_W-1:0]        iss_cnt;
  logic                    eval_vld;
  slot_idx_t               eval_idx;
  logic                    issue;
  logic                    scan_clear;

  slot_entry_t             rd_entry;
  slot_entry_t             wr_entry;
  logic                    ram_we;
  slot_idx_t               ram_waddr;
  scan_res_t               scan;

  logic                    take;
  logic signed [LEN_W-1:0] new_len;
  logic                    commit;
  logic                    in_fire;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = PDATA_W'(active_registers);

  always_ff @(posedge clk) begin
    if (rst) begin
      active_registers <= ACTIVE_RESET;
    end else if (psel && penable && pwrite && (paddr == ADDR_ACTIVE_REGISTERS)) begin
      active_registers <= pwdata[CFG_W-1:0];
    end
  end

  // Effective register count, clamped to 1..SLOT_COUNT.
  always_comb begin
    priority if (active_registers == '0) begin
      k = CNT_W'(1);
    end else if (int'(active_registers) > SLOT_COUNT) begin
      k = CNT_W'(SLOT_COUNT);
    end else begin
      k = CNT_W'(active_registers);
    end
  end

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign issue      = (state == S_SCAN) && (iss_cnt < k);
  assign scan_clear = in_fire;
  assign commit     = (state == S_DONE) && (!out_valid || out_ready);

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      eval_vld <= 1'b0;
    end else begin
      eval_vld <= issue;
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (!issue && !eval_vld) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (commit) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Scan counter and latched interval.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      cur_id    <= interval_id;
      cur_start <= interval_start;
      cur_end   <= interval_end;
      cur_last  <= last_interval;
      iss_cnt   <= '0;
    end else if (issue) begin
      iss_cnt <= iss_cnt + CNT_W'(1);
    end
    eval_idx <= iss_cnt[IDX_W-1:0];
  end

  // Slot table memory.
  assign wr_entry.vreg       = cur_id;
  assign wr_entry.start_time = cur_start;
  assign wr_entry.end_time   = cur_end;
  assign ram_we              = commit && (scan.found || take);
  assign ram_waddr           = scan.found ? scan.free_idx : scan.vic_idx;

  lsra_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOT_COUNT)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (wr_entry),
    .re    (issue),
    .raddr (iss_cnt[IDX_W-1:0]),
    .rdata (rd_entry)
  );

  lsra_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .clear       (scan_clear),
    .eval        (eval_vld),
    .eval_idx    (eval_idx),
    .entry       (rd_entry),
    .entry_valid (slot_valid[eval_idx]),
    .new_start   (cur_start),
    .res         (scan)
  );

  // Replacement decision against the chosen victim.
  assign new_len = span_of(cur_start, cur_end);

  always_comb begin
    priority if (cur_end < scan.vic_end) begin
      take = 1'b1;
    end else if (cur_end == scan.vic_end) begin
      take = (new_len > scan.vic_len) ||
             ((new_len == scan.vic_len) && (cur_id < scan.vic_vreg));
    end else begin
      take = 1'b0;
    end
  end

  // Valid bits and spill flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      spill_seen <= 1'b0;
    end else if (commit) begin
      if (cur_last) begin
        slot_valid <= '0;
        spill_seen <= 1'b0;
      end else begin
        if (scan.found) begin
          slot_valid[scan.free_idx] <= 1'b1;
        end
        spill_seen <= spill_seen || !scan.found;
      end
    end else if (eval_vld && slot_valid[eval_idx] && (rd_entry.end_time <= cur_start)) begin
      // Expire an interval that ends at or before the new start.
      slot_valid[eval_idx] <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      if (scan.found) begin
        assigned_register <= ASSIGN_W'(scan.free_idx);
      end else if (take) begin
        assigned_register <= ASSIGN_W'(scan.vic_idx);
      end else begin
        assigned_register <= '0;
      end
      spilled       <= !scan.found && !take;
      spill_event   <= !scan.found;
      evicted_valid <= !scan.found && take;
      evicted_id    <= (!scan.found && take) ? scan.vic_vreg : '0;
      any_spill     <= spill_seen || !scan.found;
    end
  end

  `include "linear_scan_register_allocator_assert.svh"

  `LSRA_ASSERT_NEXT(a_accept_starts_scan, clk, rst, in_fire, state == S_SCAN, "accept without scan")
  `LSRA_ASSERT_SAME(a_spill_needs_event, clk, rst, out_valid && spilled, spill_event, "spill without event")
  `LSRA_ASSERT_SAME(a_evict_exclusive, clk, rst, out_valid && evicted_valid, spill_event && !spilled, "bad eviction flags")
  `LSRA_ASSERT_SAME(a_event_sets_flag, clk, rst, out_valid && spill_event, any_spill, "spill flag not set")

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import lsra_pkg::*;

  // Live interval word as offered on the input channel.
  typedef struct packed {
    logic [ID_W-1:0]   vreg;
    logic [TIME_W-1:0] first_use;
    logic [TIME_W-1:0] last_use;
    logic              is_last;
    logic              wait_drain;
  } interval_t;

  // Allocation word as returned on the output channel.
  typedef struct packed {
    logic [ASSIGN_W-1:0] phys_reg;
    logic                spilled;
    logic                spill_event;
    logic                evicted_valid;
    logic [ID_W-1:0]     evicted_id;
    logic                any_spill;
  } alloc_result_t;

  localparam int PHASES         = 9;
  localparam int PHASE_ITEMS    = 136;
  localparam int DRAIN_AT       = 70;
  localparam int HOLDOFF_AT     = 300;
  localparam int HOLDOFF_CYCLES = 300;
  localparam int SETTLE_CYCLES  = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                in_valid       = 1'b0;
  logic                in_ready;
  logic [ID_W-1:0]     interval_id    = '0;
  logic [TIME_W-1:0]   interval_start = '0;
  logic [TIME_W-1:0]   interval_end   = '0;
  logic                last_interval  = 1'b0;
  logic                out_valid;
  logic                out_ready      = 1'b0;
  logic [ASSIGN_W-1:0] assigned_register;
  logic                spilled;
  logic                spill_event;
  logic                evicted_valid;
  logic [ID_W-1:0]     evicted_id;
  logic                any_spill;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [PADDR_W-1:0]  paddr          = '0;
  logic [PDATA_W-1:0]  pwdata         = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;

  // Allocator state as the checker sees it.
  logic              phys_busy [SLOT_COUNT];
  logic [ID_W-1:0]   phys_vreg [SLOT_COUNT];
  logic [TIME_W-1:0] phys_first[SLOT_COUNT];
  logic [TIME_W-1:0] phys_last [SLOT_COUNT];
  logic              spill_sticky;
  logic [CFG_W-1:0]  active_regs_cfg = ACTIVE_RESET;

  interval_t     pending_intervals[$];
  alloc_result_t expected_allocs[$];
  interval_t     offered;

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int stall_left  = 0;
  int mismatches  = 0;
  int intervals_accepted = 0;
  int allocs_checked     = 0;
  int spill_count        = 0;
  int evict_count        = 0;
  int flush_count        = 0;
  int settings_used      = 0;

  int              time_cursor = 0;
  int              seq_left    = 40;
  logic [ID_W-1:0] next_vreg   = '0;

  linear_scan_register_allocator u_top (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .interval_id       (interval_id),
    .interval_start    (interval_start),
    .interval_end      (interval_end),
    .last_interval     (last_interval),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .assigned_register (assigned_register),
    .spilled           (spilled),
    .spill_event       (spill_event),
    .evicted_valid     (evicted_valid),
    .evicted_id        (evicted_id),
    .any_spill         (any_spill),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  always #5 clk = ~clk;

  // Signed length of an interval; negative when it ends before it starts.
  function automatic int interval_length(input logic [TIME_W-1:0] first_t,
                                         input logic [TIME_W-1:0] last_t);
    return int'(last_t) - int'(first_t);
  endfunction

  // Work out the allocation for one interval and advance the slot table.
  function automatic alloc_result_t allocate(input interval_t iv);
    alloc_result_t res;
    int unsigned   k;
    int unsigned   j;
    int unsigned   v;
    int            cur_len;
    int            vic_len;
    int            new_len;
    logic          hit;
    logic          take;
    res = '0;
    hit = 1'b0;
    if (active_regs_cfg == 0) k = 1;
    else if (active_regs_cfg > SLOT_COUNT) k = SLOT_COUNT;
    else k = active_regs_cfg;

    // Retire every interval that has ended by the new start.
    for (j = 0; j < k; j++)
      if (phys_busy[j] && phys_last[j] <= iv.first_use) phys_busy[j] = 1'b0;

    // Lowest free register wins.
    for (j = 0; j < k && !hit; j++) begin
      if (!phys_busy[j]) begin
        hit = 1'b1;
        res.phys_reg = ASSIGN_W'(j);
      end
    end

    if (hit) begin
      phys_busy[res.phys_reg]  = 1'b1;
      phys_vreg[res.phys_reg]  = iv.vreg;
      phys_first[res.phys_reg] = iv.first_use;
      phys_last[res.phys_reg]  = iv.last_use;
    end else begin
      // Victim: latest end, then shortest length, then larger id.
      res.spill_event = 1'b1;
      v = 0;
      for (j = 1; j < k; j++) begin
        cur_len = interval_length(phys_first[j], phys_last[j]);
        vic_len = interval_length(phys_first[v], phys_last[v]);
        if (phys_last[j] > phys_last[v]) v = j;
        else if (phys_last[j] == phys_last[v] &&
                 (cur_len < vic_len || (cur_len == vic_len && phys_vreg[j] > phys_vreg[v])))
          v = j;
      end
      vic_len = interval_length(phys_first[v], phys_last[v]);
      new_len = interval_length(iv.first_use, iv.last_use);
      if (iv.last_use < phys_last[v]) take = 1'b1;
      else if (iv.last_use == phys_last[v])
        take = (new_len > vic_len) || (new_len == vic_len && iv.vreg < phys_vreg[v]);
      else take = 1'b0;
      if (take) begin
        res.evicted_valid = 1'b1;
        res.evicted_id    = phys_vreg[v];
        res.phys_reg      = ASSIGN_W'(v);
        phys_vreg[v]      = iv.vreg;
        phys_first[v]     = iv.first_use;
        phys_last[v]      = iv.last_use;
      end else begin
        res.spilled = 1'b1;
      end
      spill_sticky = 1'b1;
    end
    res.any_spill = spill_sticky;

    // The final interval of a run flushes the table.
    if (iv.is_last) begin
      for (j = 0; j < SLOT_COUNT; j++) phys_busy[j] = 1'b0;
      spill_sticky = 1'b0;
    end
    return res;
  endfunction

  task automatic check_field(input string what, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, what, want, got);
      mismatches++;
    end
  endtask

  task automatic push_interval(input logic [ID_W-1:0] vreg, input logic [TIME_W-1:0] first_t,
                               input logic [TIME_W-1:0] last_t, input logic is_last);
    interval_t iv;
    iv = '{vreg: vreg, first_use: first_t, last_use: last_t, is_last: is_last,
           wait_drain: 1'b0};
    pending_intervals.push_back(iv);
  endtask

  // Mostly start-ordered runs of intervals, with some noise words mixed in.
  task automatic queue_random_intervals(input int count);
    interval_t iv;
    int        n;
    int        pick;
    int        span;
    int        t;
    for (n = 0; n < count; n++) begin
      iv = '0;
      if ($urandom_range(99) < 8) begin
        iv.vreg      = ID_W'($urandom);
        iv.first_use = TIME_W'($urandom);
        iv.last_use  = TIME_W'($urandom);
        iv.is_last   = 1'($urandom_range(1));
      end else begin
        t = time_cursor + int'($urandom_range(3));
        if (t > 65535) t = 65535;
        time_cursor  = t;
        iv.first_use = TIME_W'(t);
        pick = $urandom_range(99);
        if (pick < 70) span = $urandom_range(24);
        else if (pick < 92) span = $urandom_range(400, 25);
        else if (pick < 96) span = 65535;
        else span = -int'($urandom_range(8, 1));
        t = t + span;
        if (t > 65535) t = 65535;
        if (t < 0) t = 0;
        iv.last_use = TIME_W'(t);
        if ($urandom_range(99) < 20) begin
          iv.vreg = ID_W'($urandom_range(15));
        end else begin
          iv.vreg = next_vreg;
          next_vreg++;
        end
        seq_left--;
        if (seq_left <= 0 || time_cursor == 65535) begin
          iv.is_last  = 1'b1;
          seq_left    = $urandom_range(120, 20);
          time_cursor = $urandom_range(60000);
        end
      end
      iv.wait_drain = (n == DRAIN_AT);
      pending_intervals.push_back(iv);
    end
  endtask

  // Setup cycle, then access cycle; the register takes the word on the access edge.
  task automatic write_active_registers(input logic [CFG_W-1:0] value);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ADDR_ACTIVE_REGISTERS;
    pwdata  <= ($urandom & ~PDATA_W'(32'h1F)) | PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    active_regs_cfg = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    settings_used++;
  endtask

  task automatic wait_idle();
    while (pending_intervals.size() != 0 || in_valid || expected_allocs.size() != 0)
      @(posedge clk);
  endtask

  // Driver: offers one interval word at a time from the pending queue.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_allocs.push_back(allocate(offered));
        intervals_accepted++;
        if (offered.is_last) flush_count++;
      end
      if (!in_valid || in_ready) begin
        if (pending_intervals.size() != 0 &&
            !(pending_intervals[0].wait_drain && expected_allocs.size() != 0) &&
            $urandom_range(99) >= tx_idle_pct) begin
          offered = pending_intervals.pop_front();
          in_valid       <= 1'b1;
          interval_id    <= offered.vreg;
          interval_start <= offered.first_use;
          interval_end   <= offered.last_use;
          last_interval  <= offered.is_last;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each allocation word against the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_allocs.size() == 0) begin
          $display("%0t: unexpected result, expected none actual reg=%0d", $time,
                   assigned_register);
          mismatches++;
        end else begin
          alloc_result_t want;
          want = expected_allocs.pop_front();
          check_field("assigned_register", want.phys_reg, assigned_register);
          check_field("spilled", want.spilled, spilled);
          check_field("spill_event", want.spill_event, spill_event);
          check_field("evicted_valid", want.evicted_valid, evicted_valid);
          check_field("evicted_id", want.evicted_id, evicted_id);
          check_field("any_spill", want.any_spill, any_spill);
          if (want.spilled) spill_count++;
          if (want.evicted_valid) evict_count++;
        end
        allocs_checked++;
        // One long hold-off so the block backs up and stalls its input.
        if (allocs_checked == HOLDOFF_AT) stall_left = HOLDOFF_CYCLES;
      end
      if (stall_left != 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Overall time limit.
  initial begin
    #8000000;
    $display("Regression FAIL");
    $finish;
  end

  // Stimulus sequencing: reset, directed intervals, then random phases.
  initial begin
    int               p;
    logic [CFG_W-1:0] setting;
    for (p = 0; p < SLOT_COUNT; p++) phys_busy[p] = 1'b0;
    spill_sticky = 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed part with two registers so the victim rules come up quickly.
    tx_idle_pct = 24;
    rx_idle_pct = 52;
    write_active_registers(CFG_W'(2));
    push_interval(16'd0, 16'd0, 16'd10, 1'b0);
    push_interval(16'hFFFF, 16'd0, 16'd20, 1'b0);
    push_interval(16'd5, 16'd1, 16'd5, 1'b0);        // ends earlier, takes the slot
    push_interval(16'd6, 16'd2, 16'd30, 1'b0);       // ends later, spilled itself
    push_interval(16'd7, 16'd5, 16'd10, 1'b0);       // reuses an expired slot
    push_interval(16'd8, 16'd3, 16'd10, 1'b0);       // same end, longer
    push_interval(16'd2, 16'd3, 16'd10, 1'b0);       // same end and length, smaller id
    push_interval(16'h100, 16'd3, 16'd10, 1'b0);     // same end and length, larger id
    push_interval(16'd9, 16'd12, 16'd11, 1'b1);      // negative length, flushes table
    push_interval(16'd20, 16'd100, 16'd200, 1'b0);
    push_interval(16'd30, 16'd100, 16'd200, 1'b0);
    push_interval(16'd25, 16'd100, 16'd200, 1'b0);   // victim picked on larger id
    push_interval(16'd40, 16'd150, 16'd120, 1'b0);   // negative length enters table
    push_interval(16'd41, 16'd110, 16'd200, 1'b0);
    push_interval(16'd42, 16'd0, 16'd200, 1'b0);
    push_interval(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1);
    push_interval(16'd0, 16'd0, 16'd0, 1'b0);
    push_interval(16'd1, 16'd0, 16'hFFFF, 1'b0);
    push_interval(16'd2, 16'hFFFF, 16'd0, 1'b0);
    push_interval(16'd3, 16'd0, 16'd0, 1'b0);
    push_interval(16'd4, 16'd0, 16'd1, 1'b0);
    push_interval(16'd5, 16'd0, 16'd1, 1'b0);
    push_interval(16'hFFFF, 16'd0, 16'd1, 1'b1);
    wait_idle();

    // Random phases; counts changed without a flush keep stale slots around.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: setting = CFG_W'(16);
        1: setting = CFG_W'(1);
        2: setting = CFG_W'(0);
        3: setting = CFG_W'(31);
        4: setting = CFG_W'(3);
        5: setting = CFG_W'($urandom_range(15, 2));
        6: setting = CFG_W'(17);
        7: setting = CFG_W'(8);
        default: setting = CFG_W'($urandom_range(31));
      endcase
      if (p < 3) begin
        tx_idle_pct = 24;
        rx_idle_pct = 52;
      end else if (p < 6) begin
        tx_idle_pct = 52;
        rx_idle_pct = 24;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      write_active_registers(setting);
      queue_random_intervals(PHASE_ITEMS);
      wait_idle();
    end

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Covered %0d intervals under %0d register-count settings, %0d run flushes.",
             intervals_accepted, settings_used, flush_count);
    $display("Checked %0d allocations: %0d spilled at once, %0d evictions.",
             allocs_checked, spill_count, evict_count);
    if (mismatches == 0 && expected_allocs.size() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
